// File: rtl/atlas_blit_edge_padding_assert.svh
// Assertion macros used by the checker file.
`ifndef ATLAS_BLIT_EDGE_PADDING_ASSERT_SVH
`define ATLAS_BLIT_EDGE_PADDING_ASSERT_SVH

// Clocked assertion, held off while reset is low.
`define ABEP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ABEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/abep_pkg.sv
`default_nettype none
package abep_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int MAX_PAD    = 7;
  localparam int MAX_WRITES = 64;

  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int PAD_W   = 3;
  localparam int CH_W    = 3;
  localparam int ADDR_W  = 24;
  localparam int WORD_W  = 32;
  localparam int SPAN_W  = 4;
  localparam int CNT_W   = $clog2(MAX_WRITES);
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;
  localparam int QDEPTH  = 4;

  localparam logic [CH_W-1:0] CH_GRAY = 3'd1;
  localparam logic [CH_W-1:0] CH_RGB  = 3'd3;
  localparam logic [CH_W-1:0] CH_RGBA = 3'd4;

  localparam logic [23:0] RGB_FILL   = 24'hFF_FFFF;
  localparam logic [7:0]  ALPHA_FILL = 8'hFF;

  typedef enum logic [IDX_W-1:0] {
    REG_ATLAS_WIDTH   = 3'd0,
    REG_DEST_X        = 3'd1,
    REG_DEST_Y        = 3'd2,
    REG_IMAGE_WIDTH   = 3'd3,
    REG_IMAGE_HEIGHT  = 3'd4,
    REG_PAD_SIZE      = 3'd5,
    REG_CHANNEL_COUNT = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_addr;
    logic [WORD_W-1:0] write_word;
    logic              burst_end;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] atlas_width;
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [PAD_W-1:0] pad_size;
    logic [CH_W-1:0]  channel_count;
  } cfg_t;

  // One burst of writes for the back end.
  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [WORD_W-1:0] word;
    logic [SPAN_W-1:0] rows;
    logic [SPAN_W-1:0] cols;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/abep_fifo.sv
`default_nettype none
module abep_fifo import abep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      pop_data_o,
  output logic      empty_o
);

  localparam int PTR_W = $clog2(QDEPTH);

  job_t               mem_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;

  assign full_o     = (count_q == (PTR_W+1)'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (PTR_W+1)'(1);
        2'b01:   count_q <= count_q - (PTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/abep_front.sv
`default_nettype none
module abep_front import abep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic pos_clr_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      push_o,
  output job_t      push_data_o,
  input  wire logic full_i
);

  logic [POS_W-1:0] col_q, row_q, col_d, row_d;

  logic [DIM_W-1:0] w, h, wm1, hm1, rr;
  logic             stale, first_col, last_col, first_row, last_row;
  logic [POS_W-1:0] c, r;
  logic [WORD_W-1:0] word;
  logic             supported, accept;

  // Stage 1: classified pixel.
  logic              s1_v_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [ADDR_W-1:0] s1_x_q, s1_y_q;
  logic [SPAN_W-1:0] s1_rows_q, s1_cols_q;
  // Stage 2: row product ready.
  logic              s2_v_q;
  logic [WORD_W-1:0] s2_word_q;
  logic [ADDR_W-1:0] s2_x_q, s2_prod_q;
  logic [SPAN_W-1:0] s2_rows_q, s2_cols_q;

  logic [ADDR_W+DIM_W-1:0] prod;
  logic s1_adv, s2_take;
  logic [SPAN_W-1:0] pad_span;

  always_comb begin
    w   = clamp_dim(cfg_i.image_width);
    h   = clamp_dim(cfg_i.image_height);
    wm1 = w - DIM_W'(1);
    hm1 = h - DIM_W'(1);
    stale = ({1'b0, col_q} >= w);
    c  = stale ? '0 : col_q;
    rr = stale ? ({1'b0, row_q} + DIM_W'(1)) : {1'b0, row_q};
    r  = (rr >= h) ? '0 : rr[POS_W-1:0];
    first_col = (c == '0);
    last_col  = ({1'b0, c} == wm1);
    first_row = (r == '0);
    last_row  = ({1'b0, r} == hm1);
    pad_span  = {1'b0, cfg_i.pad_size};
  end

  always_comb begin
    supported = 1'b1;
    case (cfg_i.channel_count)
      CH_GRAY: word = {in_data_i.byte_zero, RGB_FILL};
      CH_RGB:  word = {ALPHA_FILL, in_data_i.byte_two, in_data_i.byte_one,
                       in_data_i.byte_zero};
      CH_RGBA: word = {in_data_i.byte_three, in_data_i.byte_two, in_data_i.byte_one,
                       in_data_i.byte_zero};
      default: begin
        word      = '0;
        supported = 1'b0;
      end
    endcase
  end

  assign push_o      = s2_v_q && !full_i;
  assign s2_take     = !s2_v_q || push_o;
  assign s1_adv      = !s1_v_q || s2_take;
  assign in_ready_o  = s1_adv;
  assign accept      = in_valid_i && in_ready_o;
  assign prod        = s1_y_q * cfg_i.atlas_width;

  assign push_data_o.base_addr = s2_x_q + s2_prod_q;
  assign push_data_o.word      = s2_word_q;
  assign push_data_o.rows      = s2_rows_q;
  assign push_data_o.cols      = s2_cols_q;

  // Advance the raster position past the accepted pixel, or clear it on pos_clr_i.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pos_clr_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : r + POS_W'(1);
      end else begin
        col_d = c + POS_W'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (s1_adv) s1_v_q <= accept && supported;
      if (s2_take) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_word_q <= word;
      s1_x_q    <= ADDR_W'(cfg_i.dest_x) + ADDR_W'(c)
                   - (first_col ? ADDR_W'(cfg_i.pad_size) : '0);
      s1_y_q    <= ADDR_W'(cfg_i.dest_y) + ADDR_W'(r)
                   - (first_row ? ADDR_W'(cfg_i.pad_size) : '0);
      s1_rows_q <= SPAN_W'(1) + (first_row ? pad_span : '0) + (last_row ? pad_span : '0);
      s1_cols_q <= SPAN_W'(1) + (first_col ? pad_span : '0) + (last_col ? pad_span : '0);
    end
    if (s2_take) begin
      s2_word_q <= s1_word_q;
      s2_x_q    <= s1_x_q;
      s2_prod_q <= prod[ADDR_W-1:0];
      s2_rows_q <= s1_rows_q;
      s2_cols_q <= s1_cols_q;
    end
  end

endmodule
`default_nettype wire

// File: rtl/abep_back.sv
`default_nettype none
module abep_back import abep_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [DIM_W-1:0] atlas_width_i,
  input  wire logic             empty_i,
  input  wire job_t             job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o
);

  logic              busy_q, out_valid_q;
  out_t              out_q;
  logic [WORD_W-1:0] word_q;
  logic [ADDR_W-1:0] row_addr_q, cur_addr_q, next_row_addr;
  logic [SPAN_W-1:0] rows_q, cols_q, row_i_q, col_i_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              advance, emit, last_col, last;

  assign advance       = !out_valid_q || out_ready_i;
  assign emit          = advance && busy_q;
  assign pop_o         = !busy_q && !empty_i;
  assign last_col      = (col_i_q == cols_q - SPAN_W'(1));
  assign last          = (last_col && (row_i_q == rows_q - SPAN_W'(1)))
                         || (cnt_q == CNT_W'(MAX_WRITES - 1));
  assign next_row_addr = row_addr_q + ADDR_W'(atlas_width_i);
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) out_valid_q <= busy_q;
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.write_addr <= cur_addr_q;
      out_q.write_word <= word_q;
      out_q.burst_end  <= last;
    end
    if (pop_o) begin
      word_q     <= job_i.word;
      row_addr_q <= job_i.base_addr;
      cur_addr_q <= job_i.base_addr;
      rows_q     <= job_i.rows;
      cols_q     <= job_i.cols;
      row_i_q    <= '0;
      col_i_q    <= '0;
      cnt_q      <= '0;
    end else if (emit) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last_col) begin
        col_i_q    <= '0;
        row_i_q    <= row_i_q + SPAN_W'(1);
        row_addr_q <= next_row_addr;
        cur_addr_q <= next_row_addr;
      end else begin
        col_i_q    <= col_i_q + SPAN_W'(1);
        cur_addr_q <= cur_addr_q + ADDR_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/atlas_blit_edge_padding.sv
`default_nettype none
// Atlas blit with clamp-to-edge padding. Feed the pixels of one image in raster
// order on in_*; each pixel produces the atlas writes (pixel index, RGBA word) whose
// clamped source is that pixel, row-major ascending, with burst_end on the last
// write of the pixel (a burst is cut at 64 writes). Program the registers on cfg_*
// only while the block is idle; any write to a known index restarts the raster
// position at the top-left pixel. Pixels with an unsupported channel count are
// consumed and emit nothing. Timing: the front end accepts one item per cycle
// while its two-stage pipeline and the four-entry job queue have room; the back
// end loads one job at a time and makes all its writes before it takes the next,
// so an interior pixel makes one write, an edge pixel 1 + pad writes and a corner
// (1 + pad)^2. The write loop of the back end sets the sustained rate.
module atlas_blit_edge_padding import abep_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o
);

  cfg_t cfg_q;
  logic cfg_wr, pos_clr;
  logic push, full, pop, empty;
  job_t push_data, pop_data;

  // Writes are always taken; it is up to the user that the block is idle whenever one arrives.
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    pos_clr = 1'b0;
    if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ATLAS_WIDTH, REG_DEST_X, REG_DEST_Y, REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT, REG_PAD_SIZE, REG_CHANNEL_COUNT: pos_clr = 1'b1;
        default: pos_clr = 1'b0;
      endcase
    end
  end

  // Hold the register file; drop writes to unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_width   <= DIM_W'(MAX_DIM);
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.image_width   <= DIM_W'(1);
      cfg_q.image_height  <= DIM_W'(1);
      cfg_q.pad_size      <= '0;
      cfg_q.channel_count <= CH_RGBA;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ATLAS_WIDTH:   cfg_q.atlas_width   <= cfg_data_i[DIM_W-1:0];
        REG_DEST_X:        cfg_q.dest_x        <= cfg_data_i[POS_W-1:0];
        REG_DEST_Y:        cfg_q.dest_y        <= cfg_data_i[POS_W-1:0];
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[DIM_W-1:0];
        REG_PAD_SIZE:      cfg_q.pad_size      <= cfg_data_i[PAD_W-1:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CH_W-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // Front end: classify each pixel and compute the start address of its burst.
  abep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pos_clr_i   (pos_clr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Job queue decouples classification from the write loop.
  abep_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back end: walk each burst one write per cycle into the output register while the output is not stalled.
  abep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .atlas_width_i (cfg_q.atlas_width),
    .empty_i       (empty),
    .job_i         (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
`default_nettype wire

// File: rtl/abep_check.sv
`default_nettype none
`include "atlas_blit_edge_padding_assert.svh"
module abep_check import abep_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire out_t             out_data_o
);

  `ABEP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled write changed")

  `ABEP_ASSERT(a_burst_cont, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.burst_end |=> out_valid_o && (out_data_o.write_word == $past(out_data_o.write_word)), "burst broken")

  `ABEP_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "write shown in reset")

endmodule

bind atlas_blit_edge_padding abep_check u_abep_check (.*);
`default_nettype wire
